### rtl/rlts_pkg.sv
// Package for the register list transfer sequencer.
// Holds widths, item layouts, the sequencer state type and the control structs.
// No dependencies.
`default_nettype none

package rlts_pkg;

    localparam int MASK_W = 16;
    localparam int IDX_W = 4;
    localparam int ADDR_W = 32;
    localparam int BASE_W = 3;

    localparam logic [ADDR_W-1:0] STEP_WORD = 32'd2;
    localparam logic [ADDR_W-1:0] STEP_LONG = 32'd4;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 80;

    // Input item layout.
    localparam int S_MASK_LO = 0;
    localparam int S_TOREG_BIT = 16;
    localparam int S_LONG_BIT = 17;
    localparam int S_PRE_BIT = 18;
    localparam int S_POST_BIT = 19;
    localparam int S_ADDR_LO = 20;
    localparam int S_BASE_LO = 52;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMPTY
    } seq_state_t;

    typedef struct packed {
        logic load;
        logic advance;
        logic down;
        logic lng;
    } addr_ctrl_t;

    typedef struct packed {
        logic             valid;
        logic             transfer;
        logic             last;
        logic [IDX_W-1:0] reg_index;
        logic             is_write;
        logic             store_dec_base;
        logic             sign_ext;
        logic             wb_valid;
        logic             pre;
    } emit_t;

    typedef struct packed {
        logic                  transfer_valid;
        logic [ADDR_W-1:0]     access_address;
        logic [IDX_W-1:0]      register_index;
        logic                  is_write;
        logic                  store_decremented_base;
        logic                  sign_extend_word;
        logic                  writeback_valid;
        logic [ADDR_W-1:0]     writeback_address;
    } result_t;

endpackage

`default_nettype wire

### rtl/rlts_addr_unit.sv
// Address register and the shared step adder of the sequencer.
// Depends on rlts_pkg for widths and the control struct.
`default_nettype none

module rlts_addr_unit (
    input  wire logic                      aclk,
    input  wire rlts_pkg::addr_ctrl_t      ctrl,
    input  wire logic [rlts_pkg::ADDR_W-1:0] start_address,
    output logic [rlts_pkg::ADDR_W-1:0]    addr,
    output logic [rlts_pkg::ADDR_W-1:0]    addr_stepped
);
    import rlts_pkg::*;

    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [ADDR_W-1:0] step;
    logic [ADDR_W-1:0] delta;

    always_comb begin
        step = ctrl.lng ? STEP_LONG : STEP_WORD;
        delta = ctrl.down ? (ADDR_W'(0) - step) : step;
        addr_stepped = addr_reg + delta;
    end

    always_comb begin
        priority if (ctrl.load) begin
            addr_next = start_address;
        end else if (ctrl.advance) begin
            addr_next = addr_stepped;
        end else begin
            addr_next = addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
    end

    assign addr = addr_reg;

endmodule

`default_nettype wire

### rtl/rlts_ctrl.sv
// Sequencer scanning the register list one bit per cycle; set bits wait for a free slot.
// Depends on rlts_pkg for the state type and control structs.
`default_nettype none

module rlts_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [rlts_pkg::MASK_W-1:0] register_mask,
    input  wire logic                        to_registers,
    input  wire logic                        long_size,
    input  wire logic                        predecrement,
    input  wire logic                        postincrement,
    input  wire logic [rlts_pkg::BASE_W-1:0] base_register,
    input  wire logic                        slot_free,
    output logic                             ready,
    output rlts_pkg::addr_ctrl_t             addr_ctrl,
    output rlts_pkg::emit_t                  emit
);
    import rlts_pkg::*;

    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              load_reg;
    logic              lng_reg;
    logic              pre_reg;
    logic              post_reg;
    logic [BASE_W-1:0] base_reg;

    logic              bit_set;
    logic [MASK_W-1:0] rest_mask;
    logic              rest_empty;
    logic              fire;
    logic [IDX_W-1:0]  reg_idx;

    always_comb begin
        bit_set = mask_reg[idx_reg];
        rest_mask = mask_reg & ~(MASK_W'(1) << idx_reg);
        rest_empty = (rest_mask == '0);
        fire = (state_reg == ST_SCAN) && bit_set && slot_free;
        reg_idx = idx_reg ^ {IDX_W{pre_reg}};
    end

    always_comb begin
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = (register_mask == '0) ? ST_EMPTY : ST_SCAN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                state_next = (fire && rest_empty) ? ST_IDLE : ST_SCAN;
            end
            ST_EMPTY: begin
                state_next = slot_free ? ST_IDLE : ST_EMPTY;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ready = 1'b0;
        addr_ctrl = '0;
        addr_ctrl.down = pre_reg;
        addr_ctrl.lng = lng_reg;
        emit = '0;
        emit.pre = pre_reg;
        mask_next = mask_reg;
        idx_next = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                ready = 1'b1;
                addr_ctrl.load = start;
                mask_next = register_mask;
                idx_next = '0;
            end
            ST_SCAN: begin
                if (!bit_set) begin
                    idx_next = idx_reg + IDX_W'(1);
                end else if (slot_free) begin
                    idx_next = idx_reg + IDX_W'(1);
                    mask_next = rest_mask;
                    addr_ctrl.advance = 1'b1;
                end
                emit.valid = fire;
                emit.transfer = 1'b1;
                emit.last = rest_empty;
                emit.reg_index = reg_idx;
                emit.is_write = !load_reg;
                emit.store_dec_base = pre_reg && (reg_idx == {1'b1, base_reg});
                emit.sign_ext = load_reg && !lng_reg;
                emit.wb_valid = rest_empty && (pre_reg || post_reg);
            end
            ST_EMPTY: begin
                emit.valid = slot_free;
                emit.last = 1'b1;
                emit.wb_valid = pre_reg || post_reg;
            end
            default: begin
                ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        mask_reg <= mask_next;
        idx_reg <= idx_next;
        if (state_reg == ST_IDLE && start) begin
            load_reg <= to_registers;
            lng_reg <= long_size;
            pre_reg <= !to_registers && predecrement;
            post_reg <= to_registers && postincrement;
            base_reg <= base_register;
        end
    end

endmodule

`default_nettype wire

### rtl/register_list_transfer_sequencer_core.sv
// Top level of the register list transfer sequencer.
// Depends on rlts_pkg, rlts_ctrl and rlts_addr_unit.
//
// One request turns a 16-bit register list into one memory access item per
// set bit, D0 up to A7 with the address rising after each access, or in
// predecrement store mode A7 down to D0 with the address falling before each
// access. An empty list gives one item with no transfer. After a request is
// accepted, the sequencer walks the list one bit per cycle, holding on a set
// bit while m_tready stalls the output, up to and including the last set
// bit, through a single shared address adder. Results leave through an
// output register.
`default_nettype none

module register_list_transfer_sequencer_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // register_mask, to_registers, long_size, predecrement, postincrement,
    // start_address, base_register, one zero pad bit
    input  wire logic [rlts_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // transfer_valid, access_address, register_index, is_write,
    // store_decremented_base, sign_extend_word, writeback_valid,
    // writeback_address, seven zero pad bits
    output logic [rlts_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import rlts_pkg::*;

    logic              start;
    logic              slot_free;
    logic              ready;
    addr_ctrl_t        addr_ctrl;
    emit_t             emit;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] addr_stepped;
    result_t           result;

    logic              m_tvalid_reg;
    result_t           m_result_reg;
    logic              m_tlast_reg;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign start = s_tvalid && ready;
    assign s_tready = ready;

    rlts_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (start),
        .register_mask (s_tdata[S_MASK_LO +: MASK_W]),
        .to_registers  (s_tdata[S_TOREG_BIT]),
        .long_size     (s_tdata[S_LONG_BIT]),
        .predecrement  (s_tdata[S_PRE_BIT]),
        .postincrement (s_tdata[S_POST_BIT]),
        .base_register (s_tdata[S_BASE_LO +: BASE_W]),
        .slot_free     (slot_free),
        .ready         (ready),
        .addr_ctrl     (addr_ctrl),
        .emit          (emit)
    );

    rlts_addr_unit u_addr (
        .aclk          (aclk),
        .ctrl          (addr_ctrl),
        .start_address (s_tdata[S_ADDR_LO +: ADDR_W]),
        .addr          (addr),
        .addr_stepped  (addr_stepped)
    );

    always_comb begin
        result.transfer_valid = emit.transfer;
        result.access_address = '0;
        if (emit.transfer) begin
            result.access_address = emit.pre ? addr_stepped : addr;
        end
        result.register_index = emit.reg_index;
        result.is_write = emit.is_write;
        result.store_decremented_base = emit.store_dec_base;
        result.sign_extend_word = emit.sign_ext;
        result.writeback_valid = emit.wb_valid;
        result.writeback_address = '0;
        if (emit.wb_valid) begin
            result.writeback_address = emit.transfer ? addr_stepped : addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (slot_free) begin
            m_tvalid_reg <= emit.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free) begin
            m_result_reg <= result;
            m_tlast_reg <= emit.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast = m_tlast_reg;
    assign m_tdata = {7'd0,
                      m_result_reg.writeback_address,
                      m_result_reg.writeback_valid,
                      m_result_reg.sign_extend_word,
                      m_result_reg.store_decremented_base,
                      m_result_reg.is_write,
                      m_result_reg.register_index,
                      m_result_reg.access_address,
                      m_result_reg.transfer_valid};

`ifndef SYNTH
    a_wb_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_result_reg.writeback_valid |-> m_tlast)
        else $error("Writeback flagged on an item that is not the last one.");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_result_reg.transfer_valid |-> m_tlast)
        else $error("An item without a transfer is not the last one.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Sequencer ready again right after taking a request.");

    a_no_wb_addr_without_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_result_reg.writeback_valid |->
            m_result_reg.writeback_address == '0)
        else $error("Writeback address set without a writeback.");
`endif

endmodule

`default_nettype wire
